// ===== rtl/pre_pkg.sv =====
package pre_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_W       = 16;
    localparam int SLOT_W       = 4;
    localparam int TOTAL_W      = 32;
    localparam int POLICY_W     = 2;
    localparam int FRAMES_CFG_W = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 56;

    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

    localparam logic [POLICY_W-1:0]     POLICY_RESET = POL_FIFO;
    localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SWEEP,
        S_EVRD,
        S_EVWR,
        S_TOUCH,
        S_TOUCH_END,
        S_DONE
    } pre_state_t;

endpackage

// ===== rtl/pre_ram.sv =====
module pre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/page_replacement_engine_top.sv =====
// Page replacement engine: each word on s names a page; the block looks it up among the
// first frames_in_use frames (FIFO, LRU or CLOCK policy, chosen by the policy register) and returns
// one word on m with hit, fault, frame, evicted page and the saturating fault total. The
// lookup walks the frame memory one frame per cycle through its single read port. A miss
// then reads and rewrites the chosen frame, a CLOCK miss first sweeps the hand past frames
// whose use bit is set, clearing it, and under LRU a hit or a miss adds a pass that re-ranks
// every frame. One word is in flight at a time; s_tready is high only while the engine is
// idle, from the cycle after the result is loaded, and a result still held by m_tready keeps
// the next one waiting in its last state. Configuration writes are accepted every cycle.
module page_replacement_engine_top
    import pre_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // page_number
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit, fault, frame_slot, evicted_valid, evicted_page, fault_total, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    pre_state_t state_reg, state_next;

    logic [POLICY_W-1:0]     policy_reg, policy_next;
    logic [FRAMES_CFG_W-1:0] frames_reg, frames_next;

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [FW-1:0]        hand_reg, hand_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic                 chk_reg, chk_next;
    logic [FW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 hit_reg, hit_next;
    logic [FW-1:0]        hit_idx_reg, hit_idx_next;
    logic [FW-1:0]        hit_rank_reg, hit_rank_next;
    logic                 inv_found_reg, inv_found_next;
    logic [FW-1:0]        inv_idx_reg, inv_idx_next;
    logic [FW-1:0]        best_idx_reg, best_idx_next;
    logic [FW-1:0]        best_rank_reg, best_rank_next;
    logic [FW-1:0]        slot_reg, slot_next;
    logic                 wasv_reg, wasv_next;
    logic [FW-1:0]        old_rank_reg, old_rank_next;
    logic [FW-1:0]        k_reg, k_next;
    logic                 replaced_reg, replaced_next;
    logic [PAGE_BITS-1:0] evicted_reg, evicted_next;
    logic [TOTAL_W-1:0]   fault_cnt_reg, fault_cnt_next;
    logic [FRAMES-1:0]    valid_reg, valid_next;
    logic [FRAMES-1:0]    use_reg, use_next;
    logic [FRAMES-1:0]    rank_wr_reg, rank_wr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_word_reg, out_word_next;

    // frame memories
    logic                 page_we;
    logic [FW-1:0]        page_raddr;
    logic [PAGE_BITS-1:0] page_rdata;
    logic                 rank_we;
    logic [FW-1:0]        rank_waddr;
    logic [FW-1:0]        rank_wdata;
    logic [FW-1:0]        rank_rdata;

    // derived values
    logic [31:0]          fin32;
    logic [31:0]          n32;
    logic [31:0]          n32m1;
    logic [CW-1:0]        n_cur;
    logic [FW-1:0]        nm1_cur;
    logic                 is_fifo;
    logic                 is_lru;
    logic                 scan_more;
    logic                 chk_last;
    logic [FW-1:0]        rank_eff;
    logic                 page_match;
    logic [FW-1:0]        slot_inc;
    logic [FW-1:0]        hand_inc;
    logic                 touch_dec;
    logic                 out_load;
    logic [31:0]          in32;
    logic [31:0]          slot32;
    logic [31:0]          ev32;

    pre_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES),
        .AW    (FW)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (slot_reg),
        .wdata (page_reg),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    pre_ram #(
        .WIDTH (FW),
        .DEPTH (FRAMES),
        .AW    (FW)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (scan_reg[FW-1:0]),
        .rdata (rank_rdata)
    );

    assign fin32   = 32'(frames_reg);
    assign n32     = (fin32 == 32'd0) ? 32'd1 : ((fin32 > FRAMES) ? 32'(FRAMES) : fin32);
    assign n32m1   = n32 - 32'd1;
    assign n_cur   = n32[CW-1:0];
    assign nm1_cur = n32m1[FW-1:0];

    assign is_fifo    = (policy_reg == POL_FIFO);
    assign is_lru     = (policy_reg == POL_LRU);
    assign scan_more  = (scan_reg < n_cur);
    assign chk_last   = chk_reg && (chk_idx_reg == nm1_cur);
    assign rank_eff   = rank_wr_reg[chk_idx_reg] ? rank_rdata : '0;
    assign page_match = valid_reg[chk_idx_reg] && (page_rdata == page_reg);
    assign slot_inc   = (slot_reg == nm1_cur) ? '0 : slot_reg + FW'(1);
    assign hand_inc   = (hand_reg == nm1_cur) ? '0 : hand_reg + FW'(1);
    assign touch_dec  = chk_reg && (chk_idx_reg != slot_reg) && valid_reg[chk_idx_reg]
                        && wasv_reg && (rank_eff > old_rank_reg);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    assign in32   = 32'(s_tdata);
    assign slot32 = 32'(slot_reg);
    assign ev32   = 32'(evicted_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_word_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chk_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (hit_reg)
                begin
                    state_next = is_lru ? S_TOUCH : S_DONE;
                end
                else if (is_fifo || is_lru)
                begin
                    state_next = S_EVRD;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (!(scan_more && use_reg[slot_reg]))
                begin
                    state_next = S_EVRD;
                end
            end
            S_EVRD:
            begin
                state_next = S_EVWR;
            end
            S_EVWR:
            begin
                state_next = is_lru ? S_TOUCH : S_DONE;
            end
            S_TOUCH:
            begin
                if (chk_last)
                begin
                    state_next = S_TOUCH_END;
                end
            end
            S_TOUCH_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        page_we    = 1'b0;
        page_raddr = scan_reg[FW-1:0];
        rank_we    = 1'b0;
        rank_waddr = chk_idx_reg;
        rank_wdata = rank_eff - FW'(1);
        case (state_reg)
            S_EVRD:
            begin
                page_raddr = slot_reg;
            end
            S_EVWR:
            begin
                page_we = 1'b1;
            end
            S_TOUCH:
            begin
                rank_we = touch_dec;
            end
            S_TOUCH_END:
            begin
                rank_we    = 1'b1;
                rank_waddr = slot_reg;
                rank_wdata = k_reg;
            end
            default:
            begin
                page_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        policy_next    = policy_reg;
        frames_next    = frames_reg;
        page_next      = page_reg;
        hand_next      = hand_reg;
        scan_next      = scan_reg;
        chk_next       = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        inv_found_next = inv_found_reg;
        inv_idx_next   = inv_idx_reg;
        best_idx_next  = best_idx_reg;
        best_rank_next = best_rank_reg;
        slot_next      = slot_reg;
        wasv_next      = wasv_reg;
        old_rank_next  = old_rank_reg;
        k_next         = k_reg;
        replaced_next  = replaced_reg;
        evicted_next   = evicted_reg;
        fault_cnt_next = fault_cnt_reg;
        valid_next     = valid_reg;
        use_next       = use_reg;
        rank_wr_next   = rank_wr_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLICY: policy_next = cfg_data[POLICY_W-1:0];
                CFG_FRAMES: frames_next = cfg_data[FRAMES_CFG_W-1:0];
                default:    policy_next = policy_reg;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (rank_we)
        begin
            rank_wr_next[rank_waddr] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    page_next      = in32[PAGE_BITS-1:0];
                    hand_next      = (hand_reg > nm1_cur) ? '0 : hand_reg;
                    scan_next      = '0;
                    hit_next       = 1'b0;
                    inv_found_next = 1'b0;
                end
            end
            S_SCAN, S_TOUCH:
            begin
                if (scan_more)
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = scan_reg[FW-1:0];
                    scan_next    = scan_reg + CW'(1);
                end
                if (chk_reg && (state_reg == S_SCAN))
                begin
                    if (page_match && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_idx_reg;
                        hit_rank_next = rank_eff;
                    end
                    if (!valid_reg[chk_idx_reg] && !inv_found_reg)
                    begin
                        inv_found_next = 1'b1;
                        inv_idx_next   = chk_idx_reg;
                    end
                    if ((chk_idx_reg == '0) || (rank_eff < best_rank_reg))
                    begin
                        best_idx_next  = chk_idx_reg;
                        best_rank_next = rank_eff;
                    end
                end
                if (chk_reg && (state_reg == S_TOUCH))
                begin
                    if ((chk_idx_reg != slot_reg) && valid_reg[chk_idx_reg])
                    begin
                        k_next = k_reg + FW'(1);
                    end
                end
            end
            S_DECIDE:
            begin
                scan_next = '0;
                k_next    = '0;
                if (hit_reg)
                begin
                    slot_next     = hit_idx_reg;
                    wasv_next     = 1'b1;
                    old_rank_next = hit_rank_reg;
                    replaced_next = 1'b0;
                    evicted_next  = '0;
                    if (!is_fifo && !is_lru)
                    begin
                        use_next[hit_idx_reg] = 1'b1;
                    end
                end
                else if (is_fifo)
                begin
                    slot_next = hand_reg;
                    hand_next = hand_inc;
                end
                else if (is_lru)
                begin
                    slot_next     = inv_found_reg ? inv_idx_reg : best_idx_reg;
                    old_rank_next = best_rank_reg;
                end
                else
                begin
                    slot_next = hand_reg;
                end
            end
            S_SWEEP:
            begin
                if (scan_more && use_reg[slot_reg])
                begin
                    use_next[slot_reg] = 1'b0;
                    slot_next          = slot_inc;
                    scan_next          = scan_reg + CW'(1);
                end
                else
                begin
                    use_next[slot_reg] = 1'b1;
                    hand_next          = slot_inc;
                end
            end
            S_EVWR:
            begin
                wasv_next            = valid_reg[slot_reg];
                valid_next[slot_reg] = 1'b1;
                scan_next            = '0;
                k_next               = '0;
                if (valid_reg[slot_reg])
                begin
                    replaced_next = 1'b1;
                    evicted_next  = page_rdata;
                    if (fault_cnt_reg != '1)
                    begin
                        fault_cnt_next = fault_cnt_reg + TOTAL_W'(1);
                    end
                end
                else
                begin
                    replaced_next = 1'b0;
                    evicted_next  = '0;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = {1'b0, fault_cnt_reg, ev32[PAGE_W-1:0], replaced_reg,
                                      slot32[SLOT_W-1:0], replaced_reg, hit_reg};
                end
            end
            default:
            begin
                chk_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= POLICY_RESET;
            frames_reg     <= FRAMES_RESET;
            hand_reg       <= '0;
            scan_reg       <= '0;
            chk_reg        <= 1'b0;
            hit_reg        <= 1'b0;
            inv_found_reg  <= 1'b0;
            fault_cnt_reg  <= '0;
            valid_reg      <= '0;
            use_reg        <= '0;
            rank_wr_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            frames_reg     <= frames_next;
            hand_reg       <= hand_next;
            scan_reg       <= scan_next;
            chk_reg        <= chk_next;
            hit_reg        <= hit_next;
            inv_found_reg  <= inv_found_next;
            fault_cnt_reg  <= fault_cnt_next;
            valid_reg      <= valid_next;
            use_reg        <= use_next;
            rank_wr_reg    <= rank_wr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        chk_idx_reg   <= chk_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        inv_idx_reg   <= inv_idx_next;
        best_idx_reg  <= best_idx_next;
        best_rank_reg <= best_rank_next;
        slot_reg      <= slot_next;
        wasv_reg      <= wasv_next;
        old_rank_reg  <= old_rank_next;
        k_reg         <= k_next;
        replaced_reg  <= replaced_next;
        evicted_reg   <= evicted_next;
        out_word_reg  <= out_word_next;
    end

endmodule
